>>> rtl/lhp_pkg.sv
`timescale 1ns / 1ps
package lhp_pkg;
	localparam int DEF_NUM_STAGES  = 9;
	localparam int DEF_NUM_BUCKETS = 64;
	localparam int CMD_W   = 1;
	localparam int STAGE_W = 4;
	localparam int DUR_W   = 40;
	localparam int CNT_W   = 32;
	localparam int TOT_W   = 64;
	localparam int BW_W    = 30;
	localparam int IDX_W   = 6;
	localparam logic [BW_W-1:0] BW_RESET = 30'd1000000;
	localparam logic CMD_RECORD = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	typedef struct packed {
		logic             cmd;
		logic             in_range;
		logic [STAGE_W-1:0] stage;
		logic [DUR_W-1:0] dur;
	} lhp_item_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIV, ST_RD, ST_WR, ST_QDIV, ST_WALK, ST_WALKW, ST_OUT, ST_CLR
	} lhp_state_t;
endpackage

>>> rtl/lhp_ram.sv
`timescale 1ns / 1ps
module lhp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

>>> rtl/lhp_front.sv
`timescale 1ns / 1ps
module lhp_front import lhp_pkg::*; #(
	parameter int NUM_STAGES = DEF_NUM_STAGES
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic [CMD_W+STAGE_W+DUR_W-1:0] in_data,
	output logic      q_valid,
	input  logic      q_ready,
	output lhp_item_t q_item
);
	// two-entry queue toward the back end
	lhp_item_t mem_q [2];
	logic      wp_q, rp_q;
	logic [1:0] cnt_q;
	lhp_item_t item;
	always_comb begin
		item.cmd      = in_data[0];
		item.stage    = in_data[STAGE_W:1];
		item.dur      = in_data[STAGE_W+DUR_W:STAGE_W+1];
		item.in_range = {28'd0, in_data[STAGE_W:1]} < 32'(NUM_STAGES);
	end
	assign in_ready = cnt_q != 2'd2;
	assign q_valid  = cnt_q != 2'd0;
	assign q_item   = mem_q[rp_q];
	wire push = in_valid && in_ready;
	wire pop  = q_valid && q_ready;
	always_ff @(posedge clk) if (push) mem_q[wp_q] <= item;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

>>> rtl/lhp_div.sv
`timescale 1ns / 1ps
module lhp_div #(
	parameter int NW = 64,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	// restoring divider, one quotient bit per cycle
	logic [NW-1:0] q_q;
	logic [DW:0]   r_q;
	logic [DW-1:0] d_q;
	logic [$clog2(NW+1)-1:0] n_q;
	logic [DW:0] trial;
	assign trial = {r_q[DW-1:0], q_q[NW-1]};
	assign quo = q_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0; done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				n_q <= ($clog2(NW+1))'(NW);
			end else if (n_q != '0) begin
				n_q <= n_q - 1'b1;
				if (n_q == 1) done <= 1'b1;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num; r_q <= '0; d_q <= den;
		end else if (n_q != '0) begin
			if (trial >= {1'b0, d_q}) begin
				r_q <= trial - {1'b0, d_q};
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end
endmodule

>>> rtl/lhp_back.sv
`timescale 1ns / 1ps
module lhp_back import lhp_pkg::*; #(
	parameter int NUM_STAGES  = DEF_NUM_STAGES,
	parameter int NUM_BUCKETS = DEF_NUM_BUCKETS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [BW_W-1:0] bucket_width,
	input  logic            q_valid,
	output logic            q_ready,
	input  lhp_item_t       q_item,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [CNT_W-1:0] o_count,
	output logic [DUR_W-1:0] o_avg,
	output logic [DUR_W-1:0] o_max,
	output logic [IDX_W-1:0] o_p50,
	output logic [IDX_W-1:0] o_p95,
	output logic [IDX_W-1:0] o_p99
);
	localparam int SW    = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
	localparam int BKW   = $clog2(NUM_BUCKETS);
	localparam int DEPTH = NUM_STAGES * NUM_BUCKETS;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [BKW-1:0] LAST = BKW'(NUM_BUCKETS - 1);
	// reciprocals for floor(x/20) = (x*RCP20)>>36 and floor(x/100) = (x*RCP100)>>37
	localparam logic [CNT_W-1:0] RCP20  = 32'hCCCC_CCCD;
	localparam logic [CNT_W-1:0] RCP100 = 32'h51EB_851F;

	logic [CNT_W-1:0] cnt_q [NUM_STAGES];
	logic [TOT_W-1:0] tot_q [NUM_STAGES];
	logic [DUR_W-1:0] max_q [NUM_STAGES];

	lhp_state_t st_q, st_d;
	lhp_item_t  it_q;
	logic [BKW-1:0] bk_q;
	logic [AW-1:0]  clr_q;
	logic [CNT_W+1:0] cum_q;
	logic [CNT_W-1:0] t50_q, t95_q, t99_q;
	logic [CNT_W-1:0] q20_q, q100_q;
	logic f50_q, f95_q;
	logic [SW-1:0] sidx;
	assign sidx = it_q.stage[SW-1:0];

	logic div_start, div_done;
	logic [TOT_W-1:0] div_num, div_quo;
	logic [CNT_W-1:0] div_den;
	lhp_div #(.NW(TOT_W), .DW(CNT_W)) u_div (
		.clk, .arst_n, .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo));

	logic ram_we;
	logic [AW-1:0] waddr, raddr;
	logic [CNT_W-1:0] wdata, rdata;
	lhp_ram #(.WIDTH(CNT_W), .DEPTH(DEPTH)) u_ram (
		.clk, .we(ram_we), .waddr, .wdata, .raddr, .rdata);

	logic [AW-1:0] base;
	assign base = AW'(sidx * NUM_BUCKETS);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_CLR:   if (clr_q == AW'(DEPTH - 1)) st_d = ST_IDLE;
			ST_IDLE:  if (q_valid) begin
				if (!q_item.in_range) st_d = q_item.cmd ? ST_OUT : ST_IDLE;
				else st_d = q_item.cmd ? ST_QDIV : ST_DIV;
			end
			ST_DIV:   if (div_done) st_d = ST_RD;
			ST_RD:    st_d = ST_WR;
			ST_WR:    st_d = ST_IDLE;
			ST_QDIV:  if (div_done) st_d = (cnt_q[sidx] == '0) ? ST_OUT : ST_WALK;
			ST_WALK:  st_d = ST_WALKW;
			ST_WALKW: if (cum_q + {2'b0, rdata} >= {2'b0, t99_q} || bk_q == LAST)
					st_d = ST_OUT;
				else st_d = ST_WALK;
			ST_OUT:   if (out_valid && out_ready) st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_ready   = st_q == ST_IDLE;
		div_start = (st_q == ST_IDLE) && q_valid && q_item.in_range;
		div_num   = q_item.cmd ? tot_q[q_item.stage[SW-1:0]] : TOT_W'(q_item.dur);
		div_den   = q_item.cmd ? cnt_q[q_item.stage[SW-1:0]] : CNT_W'(bucket_width);
		raddr     = base + AW'(bk_q);
		ram_we    = (st_q == ST_CLR) || (st_q == ST_WR && rdata != '1);
		waddr     = (st_q == ST_CLR) ? clr_q : base + AW'(bk_q);
		wdata     = (st_q == ST_CLR) ? '0 : rdata + 1'b1;
	end

	logic [TOT_W-1:0] sum;
	logic [CNT_W+1:0] ncum;
	logic [2*CNT_W-1:0] p20, p100;
	logic [CNT_W-1:0] m20, m100;
	assign sum  = tot_q[sidx] + TOT_W'(it_q.dur);
	assign ncum = cum_q + {2'b0, rdata};
	assign p20  = {{CNT_W{1'b0}}, cnt_q[sidx]} * {{CNT_W{1'b0}}, RCP20};
	assign p100 = {{CNT_W{1'b0}}, cnt_q[sidx]} * {{CNT_W{1'b0}}, RCP100};
	// quotient times divisor, to tell whether the divide left a remainder
	assign m20  = (q20_q << 4) + (q20_q << 2);
	assign m100 = (q100_q << 6) + (q100_q << 5) + (q100_q << 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLR; clr_q <= '0; out_valid <= 1'b0;
			for (int i = 0; i < NUM_STAGES; i++) begin
				cnt_q[i] <= '0; tot_q[i] <= '0; max_q[i] <= '0;
			end
		end else begin
			st_q <= st_d;
			if (st_q == ST_CLR) clr_q <= clr_q + 1'b1;
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (st_q == ST_WR) begin
				if (cnt_q[sidx] != '1) cnt_q[sidx] <= cnt_q[sidx] + 1'b1;
				tot_q[sidx] <= (sum < tot_q[sidx]) ? '1 : sum;
				if (it_q.dur > max_q[sidx]) max_q[sidx] <= it_q.dur;
			end
			if (st_q == ST_OUT && !out_valid) out_valid <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && q_valid) begin
			it_q <= q_item; bk_q <= '0; cum_q <= '0; f50_q <= 1'b0; f95_q <= 1'b0;
			o_count <= '0; o_avg <= '0; o_max <= '0;
			o_p50 <= '0; o_p95 <= '0; o_p99 <= '0;
		end
		if (st_q == ST_DIV && div_done)
			bk_q <= (bucket_width == '0 || div_quo > TOT_W'(NUM_BUCKETS - 1)) ? LAST
				: div_quo[BKW-1:0];
		if (st_q == ST_QDIV) begin
			// count is steady during the divide: hold the reciprocal quotients
			q20_q  <= {4'd0, p20[63:36]};
			q100_q <= {5'd0, p100[63:37]};
		end
		if (st_q == ST_QDIV && div_done) begin
			// floor(c*P/100) = c - ceil(c*(100-P)/100)
			t50_q <= cnt_q[sidx] >> 1;
			t95_q <= cnt_q[sidx] - q20_q - {{(CNT_W-1){1'b0}}, m20 != cnt_q[sidx]};
			t99_q <= cnt_q[sidx] - q100_q - {{(CNT_W-1){1'b0}}, m100 != cnt_q[sidx]};
			if (cnt_q[sidx] != '0) begin
				o_count <= cnt_q[sidx];
				o_avg   <= (div_quo > TOT_W'({DUR_W{1'b1}})) ? '1 : div_quo[DUR_W-1:0];
				o_max   <= max_q[sidx];
			end
		end
		if (st_q == ST_WALKW) begin
			cum_q <= ncum;
			bk_q  <= bk_q + 1'b1;
			if (!f50_q && ncum >= {2'b0, t50_q}) begin
				f50_q <= 1'b1; o_p50 <= IDX_W'(bk_q);
			end
			if (!f95_q && ncum >= {2'b0, t95_q}) begin
				f95_q <= 1'b1; o_p95 <= IDX_W'(bk_q);
			end
			if (ncum >= {2'b0, t99_q}) o_p99 <= IDX_W'(bk_q);
		end
	end
endmodule

>>> rtl/latency_histogram_percentiles.sv
`timescale 1ns / 1ps
// Record: bucket divide, then histogram read-modify-write.
// Query: average divide, then a walk over the buckets up to p99 (no walk for an
// empty stage), then the result beat is held until taken.
// One item is worked at a time in the back end; a two-beat queue decouples input.
// Reset (arst_n, async low) clears stage registers and then sweeps the histogram
// RAM, NUM_STAGES*NUM_BUCKETS entries (576 by default), before items are taken.
module latency_histogram_percentiles import lhp_pkg::*; #(
	parameter int NUM_STAGES  = DEF_NUM_STAGES,
	parameter int NUM_BUCKETS = DEF_NUM_BUCKETS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [BW_W-1:0] cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [47:0]  s_axis_tdata,  // command, stage[3:0], duration_ns[39:0], pad
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [135:0] m_axis_tdata   // sample_count, average_ns, maximum_ns,
	                                    // median_bucket, p95_bucket, p99_bucket, pad
);
	logic [BW_W-1:0] bw_q;
	logic q_valid, q_ready;
	lhp_item_t q_item;
	logic [CNT_W-1:0] cnt;
	logic [DUR_W-1:0] avg, mx;
	logic [IDX_W-1:0] p50, p95, p99;

	// hold the bucket width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bw_q <= BW_RESET;
		else if (cfg_we) bw_q <= cfg_wdata;
	end

	lhp_front #(.NUM_STAGES(NUM_STAGES)) u_front (
		.clk, .arst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_data(s_axis_tdata[CMD_W+STAGE_W+DUR_W-1:0]),
		.q_valid, .q_ready, .q_item);

	lhp_back #(.NUM_STAGES(NUM_STAGES), .NUM_BUCKETS(NUM_BUCKETS)) u_back (
		.clk, .arst_n, .bucket_width(bw_q), .q_valid, .q_ready, .q_item,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.o_count(cnt), .o_avg(avg), .o_max(mx), .o_p50(p50), .o_p95(p95), .o_p99(p99));

	// pack the result beat, first field lowest
	assign m_axis_tdata = {6'd0, p99, p95, p50, mx, avg, cnt};
endmodule

>>> rtl/lhp_checker.sv
`timescale 1ns / 1ps
module lhp_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [135:0] m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat dropped or changed under stall");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[31:0] == 32'd0 |-> m_axis_tdata[135:32] == '0)
		else $error("empty stage gave nonzero fields");
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[31:0] != 32'd0 |->
		m_axis_tdata[117:112] <= m_axis_tdata[123:118] &&
		m_axis_tdata[123:118] <= m_axis_tdata[129:124])
		else $error("percentile buckets out of order");
	a_rst: assert property (@(posedge clk) !arst_n |-> !m_axis_tvalid)
		else $error("result valid in reset");
endmodule

bind latency_histogram_percentiles lhp_checker u_chk (
	.clk, .arst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata);
